/* hdl/rgq_pkg.sv */
package rgq_pkg;

    // One converted pixel, packed as Y<<16 | Cb<<8 | Cr
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
    } ycc_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_QUANT_FACTOR = 2'd2;

    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
    localparam logic [5:0]  QUANT_MAX        = 6'd50;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_DR_EM,
        ST_EV_WR,
        ST_OD_RD1,
        ST_OD_RD2,
        ST_OD_CALC,
        ST_OD_WR,
        ST_Q_START,
        ST_Q_RUN,
        ST_OUT_WAIT
    } state_t;

endpackage

/* hdl/rgb_to_ycbcr420_quantizer.sv */
// Pixel item: accepted in IDLE, color conversion in CONV, then row-store reads and
// writes, each store having one write port and one read port. Each result then
// passes the start state, 8 bit-serial quantizer steps, the load of the output
// register and a wait in it until taken; up to two results per item. A drain item
// yields no result with nothing pending, else one held pixel. rst_n clears control
// state at once, not stores.
module rgb_to_ycbcr420_quantizer #(
    parameter int MAX_WIDTH      = 2048,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // luma, blue_diff, red_diff
    output logic        m_tlast,   // frame_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rgq_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = (CW + 1 > 12) ? CW + 1 : 12;

    state_t state_reg, state_next;

    logic [11:0]   fw_reg;
    logic [15:0]   fh_reg;
    logic [5:0]    q_reg;
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic          pv_reg;
    logic [CW-1:0] pc_reg;
    logic          pfe_reg;
    logic          two_reg;
    logic          idx_reg;
    ycc_t          slot_reg [2];
    logic          fe0_reg;
    ycc_t          a_reg, d_reg;
    ycc_t          out_reg;
    logic          out_fe_reg;

    logic [WB-1:0] w_cur, fwx;
    logic [15:0]   h_cur;
    logic          row_end, last_row, pend_last, col_odd, row_odd;
    logic [CW-1:0] col_even, col_adv;
    logic [15:0]   row_adv;
    logic [5:0]    qs, qy, qc;
    logic [9:0]    cb_sum, cr_sum;
    ycc_t          px, ev_rd, od_rd, q_res, q_in;
    logic [23:0]   ev_rdata, od_rdata;
    logic          s_acc, conv_en, q_start, q_done;
    logic          ev_we, od_we;
    logic [CW-1:0] ev_wa, od_wa, ev_ra, od_ra;
    ycc_t          ev_wd, od_wd;

    // Frame geometry and quantizer steps
    always_comb
    begin
        fwx = WB'(fw_reg);
        if (fwx == '0)
            w_cur = WB'(1);
        else if (fwx > WB'(MAX_WIDTH))
            w_cur = WB'(MAX_WIDTH);
        else
            w_cur = fwx;
        h_cur     = (fh_reg == 16'd0) ? 16'd1 : fh_reg;
        row_end   = (WB'(col_reg) + WB'(1)) >= w_cur;
        pend_last = (WB'(pc_reg) + WB'(1)) >= w_cur;
        last_row  = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_cur};
        col_odd   = col_reg[0];
        row_odd   = row_reg[0];
        col_even  = col_reg & ~CW'(1);
        col_adv   = row_end ? '0 : col_reg + CW'(1);
        row_adv   = row_end ? (last_row ? 16'd0 : row_reg + 16'd1) : row_reg;
        qs        = (q_reg > QUANT_MAX) ? QUANT_MAX : q_reg;
        qy        = (qs >> 1) + 6'd1;
        qc        = qs + 6'd1;
        cb_sum    = 10'(a_reg.cb) + 10'(ev_rd.cb) + 10'(d_reg.cb) + 10'(px.cb);
        cr_sum    = 10'(a_reg.cr) + 10'(ev_rd.cr) + 10'(d_reg.cr) + 10'(px.cr);
    end

    assign ev_rd = ycc_t'(ev_rdata);
    assign od_rd = ycc_t'(od_rdata);
    assign s_acc = s_tvalid && s_tready;

    rgq_convert #(
        .F(COEF_FRAC_BITS)
    ) u_convert (
        .clk   (clk),
        .en    (conv_en),
        .red   (s_tdata[7:0]),
        .green (s_tdata[15:8]),
        .blue  (s_tdata[23:16]),
        .px    (px)
    );

    rgq_quant u_quant (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_start),
        .val   (q_in),
        .qy    (qy),
        .qc    (qc),
        .done  (q_done),
        .res   (q_res)
    );

    rgq_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (24)
    ) u_even_store (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_wa),
        .wdata (ev_wd),
        .raddr (ev_ra),
        .rdata (ev_rdata)
    );

    rgq_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (24)
    ) u_odd_store (
        .clk   (clk),
        .we    (od_we),
        .waddr (od_wa),
        .wdata (od_wd),
        .raddr (od_ra),
        .rdata (od_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser)
                        state_next = ST_CONV;
                    else if (pv_reg)
                        state_next = ST_DR_EM;
                end
            end
            ST_CONV:     state_next = row_odd ? ST_OD_RD1 : ST_EV_WR;
            ST_DR_EM:    state_next = ST_Q_START;
            ST_EV_WR:    state_next = pv_reg ? ST_Q_START : ST_IDLE;
            ST_OD_RD1:   state_next = ST_OD_RD2;
            ST_OD_RD2:
            begin
                if (col_odd)
                    state_next = ST_OD_CALC;
                else
                    state_next = row_end ? ST_Q_START : ST_IDLE;
            end
            ST_OD_CALC:  state_next = ST_OD_WR;
            ST_OD_WR:    state_next = ST_Q_START;
            ST_Q_START:  state_next = ST_Q_RUN;
            ST_Q_RUN:    state_next = q_done ? ST_OUT_WAIT : ST_Q_RUN;
            ST_OUT_WAIT:
            begin
                if (m_tready)
                    state_next = (two_reg && !idx_reg) ? ST_Q_START : ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Store ports, handshake and quantizer start
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        conv_en  = 1'b0;
        q_start  = 1'b0;
        q_in     = idx_reg ? slot_reg[1] : slot_reg[0];
        ev_we    = 1'b0;
        od_we    = 1'b0;
        ev_wa    = col_reg;
        od_wa    = col_reg;
        ev_wd    = px;
        od_wd    = px;
        ev_ra    = col_odd ? col_even : col_reg;
        od_ra    = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                conv_en  = s_tvalid && !s_tuser;
            end
            ST_EV_WR:
            begin
                od_we = last_row;
                ev_we = !last_row;
            end
            ST_OD_RD1:
            begin
                od_we = 1'b1;
                od_ra = col_even;
            end
            ST_OD_RD2:
            begin
                ev_ra = col_reg;
            end
            ST_OD_CALC:
            begin
                od_we = 1'b1;
                od_wa = col_even;
                od_wd = '{y: d_reg.y, cb: cb_sum[9:2], cr: cr_sum[9:2]};
            end
            ST_OD_WR:
            begin
                od_we = 1'b1;
                od_wd = '{y: px.y, cb: slot_reg[0].cb, cr: slot_reg[0].cr};
            end
            ST_Q_START:  q_start  = 1'b1;
            ST_OUT_WAIT: m_tvalid = 1'b1;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fw_reg    <= FRAME_WIDTH_RST;
            fh_reg    <= FRAME_HEIGHT_RST;
            q_reg     <= 6'd0;
            col_reg   <= '0;
            row_reg   <= 16'd0;
            pv_reg    <= 1'b0;
            pc_reg    <= '0;
            pfe_reg   <= 1'b0;
            two_reg   <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data[11:0];
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    CFG_QUANT_FACTOR: q_reg  <= cfg_data[5:0];
                    default:          q_reg  <= q_reg;
                endcase
            end
            case (state_reg)
                ST_DR_EM:
                begin
                    two_reg <= 1'b0;
                    idx_reg <= 1'b0;
                    pv_reg  <= !pend_last;
                    pc_reg  <= pend_last ? '0 : pc_reg + CW'(1);
                end
                ST_EV_WR:
                begin
                    two_reg <= 1'b0;
                    idx_reg <= 1'b0;
                    // A finished lone last row becomes the pending row
                    if (last_row && row_end)
                    begin
                        pv_reg  <= 1'b1;
                        pc_reg  <= '0;
                        pfe_reg <= 1'b1;
                    end
                    else if (pv_reg)
                    begin
                        pv_reg <= !pend_last;
                        pc_reg <= pend_last ? '0 : pc_reg + CW'(1);
                    end
                    col_reg <= col_adv;
                    row_reg <= row_adv;
                end
                ST_OD_RD2:
                begin
                    if (!col_odd)
                    begin
                        two_reg <= 1'b0;
                        idx_reg <= 1'b0;
                        if (row_end)
                        begin
                            pv_reg  <= 1'b1;
                            pc_reg  <= '0;
                            pfe_reg <= last_row;
                        end
                        col_reg <= col_adv;
                        row_reg <= row_adv;
                    end
                end
                ST_OD_CALC:
                begin
                    two_reg <= 1'b1;
                    idx_reg <= 1'b0;
                end
                ST_OD_WR:
                begin
                    if (row_end)
                    begin
                        pv_reg  <= 1'b1;
                        pc_reg  <= '0;
                        pfe_reg <= last_row;
                    end
                    col_reg <= col_adv;
                    row_reg <= row_adv;
                end
                ST_OUT_WAIT:
                begin
                    if (m_tready && two_reg && !idx_reg)
                        idx_reg <= 1'b1;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Result slots and output register
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DR_EM, ST_EV_WR:
            begin
                slot_reg[0] <= od_rd;
                fe0_reg     <= pend_last && pfe_reg;
            end
            ST_OD_RD2:
            begin
                a_reg       <= ev_rd;
                d_reg       <= od_rd;
                slot_reg[0] <= ev_rd;
                fe0_reg     <= 1'b0;
            end
            ST_OD_CALC:
            begin
                slot_reg[0] <= '{y: a_reg.y, cb: cb_sum[9:2], cr: cr_sum[9:2]};
                slot_reg[1] <= '{y: ev_rd.y, cb: cb_sum[9:2], cr: cr_sum[9:2]};
                fe0_reg     <= 1'b0;
            end
            ST_Q_RUN:
            begin
                if (q_done)
                begin
                    out_reg    <= q_res;
                    out_fe_reg <= idx_reg ? 1'b0 : fe0_reg;
                end
            end
            default:
            begin
                out_reg <= out_reg;
            end
        endcase
    end

    assign m_tdata = {out_reg.cr, out_reg.cb, out_reg.y};
    assign m_tlast = out_fe_reg;

`ifndef SYNTHESIS
    // Never take an item while a result is shown
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("input taken while result pending");

    // A delivered result is not shown again
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated");

    // Quantizer finishes only while the sequencer waits on it
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_done |-> (state_reg == ST_Q_RUN))
        else $error("quantizer done outside run state");

    // A pixel item goes to conversion next
    a_pixel_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && !s_tuser) |=> (state_reg == ST_CONV))
        else $error("pixel item not converted");
`endif
endmodule

/* hdl/rgq_ram.sv */
module rgq_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 24
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/rgq_convert.sv */
module rgq_convert #(
    parameter int F = 16
) (
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    output rgq_pkg::ycc_t     px
);
    import rgq_pkg::*;

    localparam int PW = F + 8;
    localparam int SW = F + 11;
    localparam longint ONE = 64'd1000000;
    localparam longint RND = 64'd500000;
    localparam longint K_YR  = ((longint'(299000) << F) + RND) / ONE;
    localparam longint K_YG  = ((longint'(587000) << F) + RND) / ONE;
    localparam longint K_YB  = ((longint'(114000) << F) + RND) / ONE;
    localparam longint K_CBR = ((longint'(168736) << F) + RND) / ONE;
    localparam longint K_CBG = ((longint'(331264) << F) + RND) / ONE;
    localparam longint K_HLF = ((longint'(500000) << F) + RND) / ONE;
    localparam longint K_CRG = ((longint'(418688) << F) + RND) / ONE;
    localparam longint K_CRB = ((longint'(81312) << F) + RND) / ONE;
    localparam logic signed [SW-1:0] HALF = SW'(longint'(128) << F);

    logic [PW-1:0] p_reg [9];
    logic signed [SW-1:0] ys, cbs, crs;

    function automatic logic [7:0] clamp255(input logic signed [SW-1:0] t);
        logic signed [SW-1:0] v;
        begin
            v = t >>> F;
            if (t < 0)
                clamp255 = 8'd0;
            else if (v > SW'(255))
                clamp255 = 8'd255;
            else
                clamp255 = v[7:0];
        end
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic [PW-1:0] p);
        sx = $signed({3'b000, p});
    endfunction

    // Register the nine products when a pixel item is taken
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(longint'(red)   * K_YR);
            p_reg[1] <= PW'(longint'(green) * K_YG);
            p_reg[2] <= PW'(longint'(blue)  * K_YB);
            p_reg[3] <= PW'(longint'(red)   * K_CBR);
            p_reg[4] <= PW'(longint'(green) * K_CBG);
            p_reg[5] <= PW'(longint'(blue)  * K_HLF);
            p_reg[6] <= PW'(longint'(red)   * K_HLF);
            p_reg[7] <= PW'(longint'(green) * K_CRG);
            p_reg[8] <= PW'(longint'(blue)  * K_CRB);
        end
    end

    // Sum and clamp each component
    always_comb
    begin
        ys  = sx(p_reg[0]) + sx(p_reg[1]) + sx(p_reg[2]);
        cbs = HALF - sx(p_reg[3]) - sx(p_reg[4]) + sx(p_reg[5]);
        crs = HALF + sx(p_reg[6]) - sx(p_reg[7]) - sx(p_reg[8]);
    end

    always_ff @(posedge clk)
    begin
        px.y  <= clamp255(ys);
        px.cb <= clamp255(cbs);
        px.cr <= clamp255(crs);
    end
endmodule

/* hdl/rgq_quant.sv */
module rgq_quant (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rgq_pkg::ycc_t val,
    input  logic [5:0]    qy,
    input  logic [5:0]    qc,
    output logic          done,
    output rgq_pkg::ycc_t res
);
    import rgq_pkg::*;

    logic [7:0] v_reg   [3];
    logic [7:0] sh_reg  [3];
    logic [5:0] rem_reg [3];
    logic [5:0] dv_reg  [3];
    logic [5:0] rem_next [3];
    logic [6:0] r7 [3];
    logic [2:0] cnt_reg;
    logic       busy_reg;
    logic       done_reg;

    // One restoring-division bit per lane and cycle while busy
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r7[i] = {rem_reg[i], sh_reg[i][7]};
            if (r7[i] >= {1'b0, dv_reg[i]})
                rem_next[i] = 6'(r7[i] - {1'b0, dv_reg[i]});
            else
                rem_next[i] = r7[i][5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == 3'd7);
            if (start)
            begin
                cnt_reg  <= 3'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg[0]  <= val.y;
            v_reg[1]  <= val.cb;
            v_reg[2]  <= val.cr;
            sh_reg[0] <= val.y;
            sh_reg[1] <= val.cb;
            sh_reg[2] <= val.cr;
            dv_reg[0] <= qy;
            dv_reg[1] <= qc;
            dv_reg[2] <= qc;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= 6'd0;
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= rem_next[i];
                sh_reg[i]  <= {sh_reg[i][6:0], 1'b0};
            end
        end
    end

    // Truncate to a multiple of the divisor
    assign done   = done_reg;
    assign res.y  = v_reg[0] - {2'b00, rem_reg[0]};
    assign res.cb = v_reg[1] - {2'b00, rem_reg[1]};
    assign res.cr = v_reg[2] - {2'b00, rem_reg[2]};
endmodule

/* tb/sv/rgb_to_ycbcr420_quantizer_test.sv */
`timescale 1ns / 1ps

module rgb_to_ycbcr420_quantizer_test;
    import rgq_pkg::*;

    localparam int ROW_MAX    = 2048;
    localparam int STALL_MAX  = 5000;
    localparam int SETTLE     = 40;
    localparam int PIXEL_GOAL = 700;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_item_t;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       frame_end;
    } out_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // red, green, blue
    logic        s_tuser = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // luma, blue_diff, red_diff
    logic        m_tlast;        // frame_end
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [15:0] cfg_data = '0;

    rgb_to_ycbcr420_quantizer DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pixel_item_t pending_items[$];
    out_pixel_t  expected_pixels[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count   = 0;
    int          pixel_count   = 0;
    int          drain_count   = 0;
    int          checked_count = 0;
    int          frame_count   = 0;

    // Shadow of the block's registers and row state
    logic [11:0] width_reg  = FRAME_WIDTH_RST;
    logic [15:0] height_reg = FRAME_HEIGHT_RST;
    logic [5:0]  quant_reg  = '0;
    ycc_t        even_line[ROW_MAX];
    ycc_t        odd_line[ROW_MAX];
    int          col_pos = 0;
    int          row_pos = 0;
    bit          held_valid = 0;
    int          held_col = 0;
    bit          held_frame_end = 0;

    function automatic int line_width();
        if (width_reg < 1) return 1;
        return (width_reg > ROW_MAX) ? ROW_MAX : int'(width_reg);
    endfunction

    function automatic int line_count();
        return (height_reg < 1) ? 1 : int'(height_reg);
    endfunction

    function automatic longint fixed_coef(longint micro);
        return ((micro << 16) + 500000) / 1000000;
    endfunction

    function automatic logic [7:0] sat_byte(longint acc);
        longint v;
        if (acc < 0) return 8'd0;
        v = acc >>> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic ycc_t rgb_to_ycc(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        longint rr, gg, bb, mid;
        ycc_t   p;
        rr  = r;
        gg  = g;
        bb  = b;
        mid = longint'(128) << 16;
        p.y  = sat_byte(fixed_coef(299000) * rr + fixed_coef(587000) * gg
                        + fixed_coef(114000) * bb);
        p.cb = sat_byte(mid - fixed_coef(168736) * rr - fixed_coef(331264) * gg
                        + fixed_coef(500000) * bb);
        p.cr = sat_byte(mid + fixed_coef(500000) * rr - fixed_coef(418688) * gg
                        - fixed_coef(81312) * bb);
        return p;
    endfunction

    // Quantize and queue one output pixel
    task automatic queue_output(ycc_t src, logic [7:0] cb, logic [7:0] cr, bit fe);
        int         q, qc, qy;
        out_pixel_t o;
        q  = (quant_reg > QUANT_MAX) ? int'(QUANT_MAX) : int'(quant_reg);
        qc = q + 1;
        qy = q / 2 + 1;
        o.luma      = 8'((int'(src.y) / qy) * qy);
        o.cb        = 8'((int'(cb) / qc) * qc);
        o.cr        = 8'((int'(cr) / qc) * qc);
        o.frame_end = fe;
        expected_pixels = {expected_pixels, o};
    endtask

    task automatic release_held();
        ycc_t p;
        bit   last;
        if (!held_valid) return;
        p    = odd_line[(held_col >= ROW_MAX) ? ROW_MAX - 1 : held_col];
        last = (held_col + 1 >= line_width());
        queue_output(p, p.cb, p.cr, last && held_frame_end);
        if (last)
        begin
            held_valid = 0;
            held_col   = 0;
        end
        else
            held_col++;
    endtask

    // Advance the shadow state by one accepted item
    task automatic predict_item(pixel_item_t it);
        ycc_t px, a, b, d;
        int   c, cb_sum, cr_sum;
        bit   row_end, last_row;
        logic [7:0] cbv, crv;
        if (it.cmd == CMD_DRAIN)
        begin
            release_held();
            return;
        end
        c        = (col_pos >= ROW_MAX) ? ROW_MAX - 1 : col_pos;
        row_end  = (col_pos + 1 >= line_width());
        last_row = (row_pos + 1 >= line_count());
        px       = rgb_to_ycc(it.red, it.green, it.blue);
        if (row_pos % 2 == 0)
        begin
            release_held();
            if (last_row)
            begin
                odd_line[c] = px;
                if (row_end)
                begin
                    held_valid     = 1;
                    held_col       = 0;
                    held_frame_end = 1;
                end
            end
            else
                even_line[c] = px;
        end
        else
        begin
            odd_line[c] = px;
            if (c % 2 == 1)
            begin
                a      = even_line[c - 1];
                b      = even_line[c];
                d      = odd_line[c - 1];
                cb_sum = int'(a.cb) + int'(b.cb) + int'(d.cb) + int'(px.cb);
                cr_sum = int'(a.cr) + int'(b.cr) + int'(d.cr) + int'(px.cr);
                cbv    = 8'(cb_sum >> 2);
                crv    = 8'(cr_sum >> 2);
                queue_output(a, cbv, crv, 0);
                queue_output(b, cbv, crv, 0);
                odd_line[c - 1] = '{d.y, cbv, crv};
                odd_line[c]     = '{px.y, cbv, crv};
            end
            else if (row_end)
            begin
                b = even_line[c];
                queue_output(b, b.cb, b.cr, 0);
            end
            if (row_end)
            begin
                held_valid     = 1;
                held_col       = 0;
                held_frame_end = last_row;
            end
        end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
            if (last_row) frame_count++;
        end
        else
            col_pos++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Item driver: predict on acceptance, then present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        pixel_item_t nxt;
        pixel_item_t cur;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                cur.cmd   = s_tuser;
                cur.red   = s_tdata[7:0];
                cur.green = s_tdata[15:8];
                cur.blue  = s_tdata[23:16];
                predict_item(cur);
                if (cur.cmd == CMD_DRAIN) drain_count++;
                else pixel_count++;
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= {nxt.blue, nxt.green, nxt.red};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result monitor: compare with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        out_pixel_t e;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected result, luma", m_tdata[7:0], -1);
                else
                begin
                    e = expected_pixels.pop_front();
                    checked_count++;
                    if (m_tdata[7:0] !== e.luma)
                        report_mismatch("luma", m_tdata[7:0], e.luma);
                    if (m_tdata[15:8] !== e.cb)
                        report_mismatch("blue_diff", m_tdata[15:8], e.cb);
                    if (m_tdata[23:16] !== e.cr)
                        report_mismatch("red_diff", m_tdata[23:16], e.cr);
                    if (m_tlast !== e.frame_end)
                        report_mismatch("frame_end", m_tlast, e.frame_end);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted item, delivered result or register write
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("watchdog expired with %0d results outstanding", expected_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_item_t it;
        it.cmd   = cmd;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        pending_items = {pending_items, it};
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Wait until the block is idle, then empty the held row with drain items
    task automatic settle_block();
        int n;
        forever
        begin
            while (pending_items.size() > 0 || s_tvalid || expected_pixels.size() > 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            if (!held_valid) break;
            n = line_width() - held_col;
            repeat (n) push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg  = val[11:0];
            CFG_FRAME_HEIGHT: height_reg = val;
            CFG_QUANT_FACTOR: quant_reg  = val[5:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_frame(logic [15:0] w, logic [15:0] h, logic [15:0] q);
        settle_block();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_QUANT_FACTOR, q);
    endtask

    // Queue one random frame with the current geometry, drains mixed in
    task automatic queue_random_frame();
        int total;
        total = line_width() * line_count();
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(99) < 8)
                push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            push_item(CMD_PIXEL, rand_level(), rand_level(), rand_level());
        end
    endtask

    // Stimulus
    initial
    begin
        int queued;
        while (!rst_n) @(posedge clk);
        send_idle_pct = 38;
        recv_idle_pct = 51;

        // Drain with nothing held, then a 4x2 frame of extreme colors
        setup_frame(16'd4, 16'd2, 16'd0);
        push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        push_item(CMD_PIXEL, 8'd255, 8'd0, 8'd0);
        push_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0);
        push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd255);
        push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd0);
        push_item(CMD_DRAIN, 8'd255, 8'd255, 8'd255);
        push_item(CMD_PIXEL, 8'd0, 8'd255, 8'd255);
        push_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255);

        // Lone last column and lone last row, quant factor beyond its range
        setup_frame(16'd3, 16'd3, 16'd63);
        for (int i = 0; i < 9; i++)
            push_item(CMD_PIXEL, 8'(i * 31), 8'(255 - i * 29), 8'(i * 17));

        // Zero width and height, maximum quant factor
        setup_frame(16'd0, 16'd0, 16'd50);
        push_item(CMD_PIXEL, 8'd255, 8'd128, 8'd0);

        // Random frames under three idling patterns
        queued = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 38 : 0;
            while (queued < PIXEL_GOAL * (phase + 1) / 3)
            begin
                setup_frame(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                            16'($urandom_range(0, 63)));
                queued += line_width() * line_count();
                queue_random_frame();
            end
        end
        settle_block();

        $display("covered %0d frames: %0d pixel items, %0d drain items, %0d results checked",
                 frame_count, pixel_count, drain_count, checked_count);
        $display("widths 0 to 12, heights 0 to 6, quant factors 0 to 63");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rgq_pkg.sv
hdl/rgq_ram.sv
hdl/rgq_convert.sv
hdl/rgq_quant.sv
hdl/rgb_to_ycbcr420_quantizer.sv
tb/sv/rgb_to_ycbcr420_quantizer_test.sv
